// ----- design/colour_ramp_interpolator_macros.svh -----
// assertion macros for the colour ramp interpolator
// used by the design modules, relies on clk and rst_n in the including scope
`ifndef COLOUR_RAMP_INTERPOLATOR_MACROS_SVH
`define COLOUR_RAMP_INTERPOLATOR_MACROS_SVH

// property holds at every edge out of reset
`define CRI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CRI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define CRI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/cri_pkg.sv -----
// shared constants, types and helper functions of the colour ramp interpolator
// no dependencies
package cri_pkg;

  // table geometry and time format
  localparam int MAX_KEYS  = 8;
  localparam int TIME_BITS = 16;
  localparam int TW        = TIME_BITS + 1;
  localparam int IW        = $clog2(MAX_KEYS);
  localparam int HW        = $clog2(MAX_KEYS + 1);
  // divider: quotient bits and numerator width
  localparam int QB        = TW;
  localparam int NW        = 32 + QB;
  localparam logic [TW-1:0] TIME_ONE = {1'b1, {TIME_BITS{1'b0}}};

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_AFFECT = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // colour operation and particle kind
  localparam logic CAO_SET      = 1'b0;
  localparam logic CAO_MULTIPLY = 1'b1;
  localparam logic KIND_VISUAL  = 1'b1;

  // register index
  localparam logic REG_COLOUR_MULTIPLY = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ISCAN,
    ST_FDIV,
    ST_KSCAN,
    ST_CH_BEGIN,
    ST_CH_MUL,
    ST_CH_DSTART,
    ST_CH_DWAIT,
    ST_CH_MIX,
    ST_CH_SCALE,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // one 8-bit channel of a packed rgba colour, red first
  function automatic logic [7:0] chan_of(input logic [31:0] c, input logic [1:0] ch);
    logic [7:0] v;
    case (ch)
      2'd0:    v = c[31:24];
      2'd1:    v = c[23:16];
      2'd2:    v = c[15:8];
      default: v = c[7:0];
    endcase
    return v;
  endfunction

  // floor(x / 255) for x below 65280, estimate plus one correction
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] sum;
    logic [7:0]  est;
    logic [16:0] r;
    sum = x + {8'd0, x[15:8]};
    est = sum[15:8];
    r   = {1'b0, x} - 17'({9'd0, est} * 17'd255);
    if (r >= 17'd255) begin
      est = est + 8'd1;
    end
    return est;
  endfunction

endpackage

// ----- design/cri_if.sv -----
// input and result channel interfaces of the colour ramp interpolator
// no dependencies
interface cri_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [16:0] key_time;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        is_visual;
  logic [31:0] total_life;
  logic [31:0] remaining_life;
  modport source (output valid, req_type, key_time, red, green, blue, alpha, is_visual,
                  total_life, remaining_life, input ready);
  modport sink (input valid, req_type, key_time, red, green, blue, alpha, is_visual,
                total_life, remaining_life, output ready);
endinterface

interface cri_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       colour_written;
  logic       status;
  logic [3:0] key_count;
  modport source (output valid, out_red, out_green, out_blue, out_alpha, colour_written,
                  status, key_count, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, colour_written,
                status, key_count, output ready);
endinterface

// ----- design/colour_ramp_interpolator.sv -----
// top level: key table, sequencer and apb register of the colour ramp interpolator
// depends on cri_pkg, cri_if, cri_div and colour_ramp_interpolator_macros.svh
//
//  channel  | dir | handshake       | payload
//  in_ch    | in  | valid / ready   | req_type key_time rgba is_visual life
//  out_ch   | out | valid / ready   | rgba colour_written status key_count
//  apb      | in  | psel / penable  | colour_multiply at byte address 0
//
// one item at a time; in_ch.ready is high only in the idle state
// clear and unused requests go straight to the result; insert runs a sequential key scan
// affect: runs on the shared bit-serial divider
//   (life fraction when the life is valid, then one divide per interpolated channel)
// a result waits in the output register while the next item is taken
// reset is synchronous active low and empties the key table
`include "colour_ramp_interpolator_macros.svh"

module colour_ramp_interpolator (
  input  logic        clk,
  input  logic        rst_n,
  cri_in_if.sink      in_ch,
  cri_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TW = cri_pkg::TW;
  localparam int IW = cri_pkg::IW;
  localparam int HW = cri_pkg::HW;
  localparam int MK = cri_pkg::MAX_KEYS;

  cri_pkg::st_t state_r, state_nxt;

  logic [TW-1:0] times_r [MK];
  logic [TW-1:0] times_nxt [MK];
  logic [31:0]   cols_r [MK];
  logic [31:0]   cols_nxt [MK];
  logic [HW-1:0] held_r, held_nxt;
  logic          mult_r, mult_nxt;

  logic [HW-1:0] idx_r, idx_nxt;
  logic [1:0]    ch_r, ch_nxt;
  logic          have_next_r, have_next_nxt;
  logic [TW-1:0] t_new_r, t_new_nxt;
  logic [31:0]   col_new_r, col_new_nxt;
  logic [TW-1:0] frac_r, frac_nxt;
  logic [TW-1:0] t1_r, t1_nxt, t2_r, t2_nxt;
  logic [31:0]   c1_r, c1_nxt, c2_r, c2_nxt;
  logic [8+TW-1:0] prod_r, prod_nxt;
  logic [15:0]   mprod_r, mprod_nxt;
  logic [7:0]    col_r, col_nxt;
  logic [7:0]    origc_r [4];
  logic [7:0]    origc_nxt [4];
  logic [7:0]    resc_r [4];
  logic [7:0]    resc_nxt [4];
  logic          res_written_r, res_written_nxt;
  logic          res_status_r, res_status_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_red_r, out_red_nxt, out_green_r, out_green_nxt;
  logic [7:0]    out_blue_r, out_blue_nxt, out_alpha_r, out_alpha_nxt;
  logic          out_written_r, out_written_nxt, out_status_r, out_status_nxt;
  logic [3:0]    out_count_r, out_count_nxt;

  logic                   div_start;
  logic [cri_pkg::NW-1:0] div_num;
  logic [31:0]            div_den;
  cri_pkg::div_stat_t     div_stat;
  logic [cri_pkg::QB-1:0] div_quo;

  logic          in_acc, out_free, cfg_wr;
  logic [31:0]   kt32, life_diff;
  logic [TW-1:0] t_sat, rd_t, dt, span;
  logic [31:0]   rd_c;
  logic          in_rng;
  logic [7:0]    c1ch, c2ch, mag, q8;

  cri_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // handshakes and apb
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == cri_pkg::ST_IDLE);
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == cri_pkg::REG_COLOUR_MULTIPLY) ? {31'd0, mult_r} : 32'd0;

  // operand preparation
  assign kt32      = 32'(in_ch.key_time);
  assign t_sat     = (kt32 > 32'(cri_pkg::TIME_ONE)) ? cri_pkg::TIME_ONE : TW'(kt32);
  assign life_diff = in_ch.total_life - in_ch.remaining_life;
  assign rd_t      = times_r[idx_r[IW-1:0]];
  assign rd_c      = cols_r[idx_r[IW-1:0]];
  assign in_rng    = idx_r < held_r;
  assign c1ch      = cri_pkg::chan_of(c1_r, ch_r);
  assign c2ch      = cri_pkg::chan_of(c2_r, ch_r);
  assign mag       = (c2ch >= c1ch) ? (c2ch - c1ch) : (c1ch - c2ch);
  assign dt        = frac_r - t1_r;
  assign span      = t2_r - t1_r;
  assign q8        = div_quo[7:0];

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    times_nxt       = times_r;
    cols_nxt        = cols_r;
    held_nxt        = held_r;
    mult_nxt        = mult_r;
    idx_nxt         = idx_r;
    ch_nxt          = ch_r;
    have_next_nxt   = have_next_r;
    t_new_nxt       = t_new_r;
    col_new_nxt     = col_new_r;
    frac_nxt        = frac_r;
    t1_nxt          = t1_r;
    t2_nxt          = t2_r;
    c1_nxt          = c1_r;
    c2_nxt          = c2_r;
    prod_nxt        = prod_r;
    mprod_nxt       = mprod_r;
    col_nxt         = col_r;
    origc_nxt       = origc_r;
    resc_nxt        = resc_r;
    res_written_nxt = res_written_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r;
    out_red_nxt     = out_red_r;
    out_green_nxt   = out_green_r;
    out_blue_nxt    = out_blue_r;
    out_alpha_nxt   = out_alpha_r;
    out_written_nxt = out_written_r;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;
    div_start       = 1'b0;
    div_num         = '0;
    div_den         = '0;

    // register write
    if (cfg_wr && paddr[2] == cri_pkg::REG_COLOUR_MULTIPLY) begin
      mult_nxt = pwdata[0];
    end

    // result beat taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      cri_pkg::ST_IDLE: begin
        if (in_acc) begin
          origc_nxt[0]    = in_ch.red;
          origc_nxt[1]    = in_ch.green;
          origc_nxt[2]    = in_ch.blue;
          origc_nxt[3]    = in_ch.alpha;
          for (int i = 0; i < 4; i++) begin
            resc_nxt[i] = 8'd0;
          end
          res_status_nxt  = 1'b0;
          res_written_nxt = 1'b0;
          idx_nxt         = '0;
          ch_nxt          = 2'd0;
          have_next_nxt   = 1'b0;
          t_new_nxt       = t_sat;
          col_new_nxt     = {in_ch.red, in_ch.green, in_ch.blue, in_ch.alpha};
          case (in_ch.req_type)
            cri_pkg::REQ_INSERT: begin
              state_nxt = cri_pkg::ST_ISCAN;
            end
            cri_pkg::REQ_CLEAR: begin
              held_nxt  = '0;
              state_nxt = cri_pkg::ST_DONE;
            end
            cri_pkg::REQ_AFFECT: begin
              resc_nxt[0] = in_ch.red;
              resc_nxt[1] = in_ch.green;
              resc_nxt[2] = in_ch.blue;
              resc_nxt[3] = in_ch.alpha;
              if (held_r == '0 || in_ch.is_visual != cri_pkg::KIND_VISUAL) begin
                state_nxt = cri_pkg::ST_DONE;
              end else if (in_ch.total_life != 32'd0 &&
                           in_ch.remaining_life <= in_ch.total_life) begin
                div_start = 1'b1;
                div_num   = cri_pkg::NW'({life_diff, {cri_pkg::TIME_BITS{1'b0}}});
                div_den   = in_ch.total_life;
                state_nxt = cri_pkg::ST_FDIV;
              end else begin
                frac_nxt  = '0;
                state_nxt = cri_pkg::ST_KSCAN;
              end
            end
            default: begin
              state_nxt = cri_pkg::ST_DONE;
            end
          endcase
        end
      end

      // walk to the first key at or after the new time
      cri_pkg::ST_ISCAN: begin
        if (in_rng && rd_t < t_new_r) begin
          idx_nxt = idx_r + HW'(1);
        end else begin
          if (in_rng && rd_t == t_new_r) begin
            cols_nxt[idx_r[IW-1:0]] = col_new_r;
          end else if (held_r == HW'(MK)) begin
            res_status_nxt = 1'b1;
          end else begin
            for (int j = 1; j < MK; j++) begin
              if (HW'(j) > idx_r && HW'(j) <= held_r) begin
                times_nxt[j] = times_r[j-1];
                cols_nxt[j]  = cols_r[j-1];
              end
            end
            times_nxt[idx_r[IW-1:0]] = t_new_r;
            cols_nxt[idx_r[IW-1:0]]  = col_new_r;
            held_nxt = held_r + HW'(1);
          end
          state_nxt = cri_pkg::ST_DONE;
        end
      end

      cri_pkg::ST_FDIV: begin
        if (div_stat.done) begin
          frac_nxt  = div_quo;
          state_nxt = cri_pkg::ST_KSCAN;
        end
      end

      // last key at or before the fraction, and the key after it
      cri_pkg::ST_KSCAN: begin
        if (idx_r == '0 || rd_t <= frac_r) begin
          t1_nxt        = rd_t;
          c1_nxt        = rd_c;
          have_next_nxt = 1'b0;
        end else if (!have_next_r) begin
          t2_nxt        = rd_t;
          c2_nxt        = rd_c;
          have_next_nxt = 1'b1;
        end
        idx_nxt = idx_r + HW'(1);
        if (idx_r + HW'(1) == held_r) begin
          state_nxt = cri_pkg::ST_CH_BEGIN;
        end
      end

      cri_pkg::ST_CH_BEGIN: begin
        if (have_next_r && frac_r > t1_r) begin
          state_nxt = cri_pkg::ST_CH_MUL;
        end else begin
          col_nxt   = c1ch;
          state_nxt = cri_pkg::ST_CH_MIX;
        end
      end

      cri_pkg::ST_CH_MUL: begin
        prod_nxt  = (8+TW)'(mag) * (8+TW)'(dt);
        state_nxt = cri_pkg::ST_CH_DSTART;
      end

      // rounded quotient (2*mag*dt + span) / (2*span)
      cri_pkg::ST_CH_DSTART: begin
        div_start = 1'b1;
        div_num   = cri_pkg::NW'({prod_r, 1'b0}) + cri_pkg::NW'(span);
        div_den   = 32'({span, 1'b0});
        state_nxt = cri_pkg::ST_CH_DWAIT;
      end

      cri_pkg::ST_CH_DWAIT: begin
        if (div_stat.done) begin
          col_nxt   = (c2ch >= c1ch) ? (c1ch + q8) : (c1ch - q8);
          state_nxt = cri_pkg::ST_CH_MIX;
        end
      end

      cri_pkg::ST_CH_MIX: begin
        if (mult_r == cri_pkg::CAO_MULTIPLY) begin
          mprod_nxt = 16'(col_r) * 16'(origc_r[ch_r]);
          state_nxt = cri_pkg::ST_CH_SCALE;
        end else begin
          resc_nxt[ch_r] = col_r;
          if (ch_r == 2'd3) begin
            res_written_nxt = 1'b1;
            state_nxt       = cri_pkg::ST_DONE;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            state_nxt = cri_pkg::ST_CH_BEGIN;
          end
        end
      end

      cri_pkg::ST_CH_SCALE: begin
        resc_nxt[ch_r] = cri_pkg::div255(mprod_r + 16'd127);
        if (ch_r == 2'd3) begin
          res_written_nxt = 1'b1;
          state_nxt       = cri_pkg::ST_DONE;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = cri_pkg::ST_CH_BEGIN;
        end
      end

      // hand the result to the output register
      cri_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_red_nxt     = resc_r[0];
          out_green_nxt   = resc_r[1];
          out_blue_nxt    = resc_r[2];
          out_alpha_nxt   = resc_r[3];
          out_written_nxt = res_written_r;
          out_status_nxt  = res_status_r;
          out_count_nxt   = 4'(held_r);
          state_nxt       = cri_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = cri_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= cri_pkg::ST_IDLE;
      held_r        <= '0;
      mult_r        <= cri_pkg::CAO_SET;
      out_valid_r   <= 1'b0;
      idx_r         <= '0;
      ch_r          <= 2'd0;
      have_next_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      held_r        <= held_nxt;
      mult_r        <= mult_nxt;
      out_valid_r   <= out_valid_nxt;
      idx_r         <= idx_nxt;
      ch_r          <= ch_nxt;
      have_next_r   <= have_next_nxt;
    end
  end

  // key table and working payload
  always_ff @(posedge clk) begin
    times_r       <= times_nxt;
    cols_r        <= cols_nxt;
    t_new_r       <= t_new_nxt;
    col_new_r     <= col_new_nxt;
    frac_r        <= frac_nxt;
    t1_r          <= t1_nxt;
    t2_r          <= t2_nxt;
    c1_r          <= c1_nxt;
    c2_r          <= c2_nxt;
    prod_r        <= prod_nxt;
    mprod_r       <= mprod_nxt;
    col_r         <= col_nxt;
    origc_r       <= origc_nxt;
    resc_r        <= resc_nxt;
    res_written_r <= res_written_nxt;
    res_status_r  <= res_status_nxt;
    out_red_r     <= out_red_nxt;
    out_green_r   <= out_green_nxt;
    out_blue_r    <= out_blue_nxt;
    out_alpha_r   <= out_alpha_nxt;
    out_written_r <= out_written_nxt;
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
  end

  // result beat
  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_red        = out_red_r;
  assign out_ch.out_green      = out_green_r;
  assign out_ch.out_blue       = out_blue_r;
  assign out_ch.out_alpha      = out_alpha_r;
  assign out_ch.colour_written = out_written_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.key_count      = out_count_r;

  // checks
  `CRI_ASSERT_IMPL(a_idle_div_free, state_r == cri_pkg::ST_IDLE, !div_stat.busy, "divider busy while idle")
  `CRI_ASSERT_IMPL(a_div_done_wait, div_stat.done, state_r == cri_pkg::ST_FDIV || state_r == cri_pkg::ST_CH_DWAIT, "divider result not awaited")
  `CRI_ASSERT(a_held_max, held_r <= HW'(MK), "key count above table size")
  `CRI_ASSERT_NEXT(a_accept_busy, in_acc, state_r != cri_pkg::ST_IDLE, "accepted beat not worked on")

endmodule

// ----- design/cri_div.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on cri_pkg
module cri_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [cri_pkg::NW-1:0]  num,
  input  logic [31:0]             den,
  output cri_pkg::div_stat_t      stat,
  output logic [cri_pkg::QB-1:0]  quo
);

  localparam int CW = $clog2(cri_pkg::QB + 1);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [31:0]            rem_r, rem_nxt;
  logic [31:0]            den_r, den_nxt;
  logic [cri_pkg::QB-1:0] quo_r, quo_nxt;
  logic [32:0]            trial;
  logic                   ge;

  // one trial subtract per cycle
  always_comb begin
    trial    = {rem_r, quo_r[cri_pkg::QB-1]};
    ge       = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      rem_nxt  = num[cri_pkg::NW-1:cri_pkg::QB];
      quo_nxt  = num[cri_pkg::QB-1:0];
      den_nxt  = den;
      cnt_nxt  = CW'(cri_pkg::QB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      quo_nxt = {quo_r[cri_pkg::QB-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operands
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

endmodule

// ----- dv/cri_ramp_checker.sv -----
// colour ramp checker: tracks the key table and multiply mode from the observed beats,
// predicts each result and compares it with the result channel
// depends on cri_pkg and the cri_in_if / cri_out_if interfaces
`timescale 1ns / 1ps

module cri_ramp_checker (
  input  logic        clk,
  input  logic        rst_n,
  cri_in_if           in_ch,
  cri_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          colours_pending,
  output int          req_beats,
  output int          written_beats
);

  typedef struct packed {
    logic [7:0] r, g, b, a;
    logic       written;
    logic       full;
    logic [3:0] count;
  } ramp_result_t;

  logic [cri_pkg::TW-1:0] key_time_tab [cri_pkg::MAX_KEYS];
  logic [31:0]            key_rgba_tab [cri_pkg::MAX_KEYS];
  int                     keys_stored;
  logic                   mult_mode;
  ramp_result_t           colour_q [$];

  // rounded linear blend of one channel between two keys
  function automatic logic [7:0] blend(input logic [7:0] c1, input logic [7:0] c2,
                                       input longint unsigned dt, input longint unsigned span);
    longint unsigned mag, q;
    mag = (c2 >= c1) ? c2 - c1 : c1 - c2;
    q   = (2 * mag * dt + span) / (2 * span);
    return (c2 >= c1) ? c1 + 8'(q) : c1 - 8'(q);
  endfunction

  // apply one request beat to the table and return the result it should give
  function automatic ramp_result_t next_colour();
    ramp_result_t           res;
    logic [cri_pkg::TW-1:0] t;
    logic [31:0]            rgba;
    logic [7:0]             orig [4];
    logic [7:0]             c1, c2, c;
    longint unsigned        tot, rem, frac;
    int                     i, k;
    res  = '0;
    orig = '{in_ch.red, in_ch.green, in_ch.blue, in_ch.alpha};
    case (in_ch.req_type)
      cri_pkg::REQ_INSERT: begin
        t    = (in_ch.key_time > cri_pkg::TIME_ONE) ? cri_pkg::TIME_ONE : in_ch.key_time;
        rgba = {in_ch.red, in_ch.green, in_ch.blue, in_ch.alpha};
        i = 0;
        while (i < keys_stored && key_time_tab[i] < t) i++;
        if (i < keys_stored && key_time_tab[i] == t) begin
          key_rgba_tab[i] = rgba;
        end else if (keys_stored >= cri_pkg::MAX_KEYS) begin
          res.full = 1'b1;
        end else begin
          for (k = keys_stored; k > i; k--) begin
            key_time_tab[k] = key_time_tab[k-1];
            key_rgba_tab[k] = key_rgba_tab[k-1];
          end
          key_time_tab[i] = t;
          key_rgba_tab[i] = rgba;
          keys_stored++;
        end
      end
      cri_pkg::REQ_CLEAR: keys_stored = 0;
      cri_pkg::REQ_AFFECT: begin
        {res.r, res.g, res.b, res.a} = {orig[0], orig[1], orig[2], orig[3]};
        if (keys_stored != 0 && in_ch.is_visual == cri_pkg::KIND_VISUAL) begin
          tot  = in_ch.total_life;
          rem  = in_ch.remaining_life;
          frac = 0;
          if (tot != 0 && rem <= tot) frac = ((tot - rem) << cri_pkg::TIME_BITS) / tot;
          k = 0;
          for (i = 0; i < keys_stored; i++)
            if (key_time_tab[i] <= frac) k = i;
          for (i = 0; i < 4; i++) begin
            c1 = key_rgba_tab[k][31-8*i -: 8];
            if (frac > key_time_tab[k] && k + 1 < keys_stored) begin
              c2 = key_rgba_tab[k+1][31-8*i -: 8];
              c  = blend(c1, c2, frac - key_time_tab[k],
                         key_time_tab[k+1] - key_time_tab[k]);
            end else begin
              c = c1;
            end
            if (mult_mode == cri_pkg::CAO_MULTIPLY) c = 8'((16'(c) * orig[i] + 127) / 255);
            case (i)
              0: res.r = c;
              1: res.g = c;
              2: res.b = c;
              default: res.a = c;
            endcase
          end
          res.written = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = 4'(keys_stored);
    return res;
  endfunction

  // register writes, request beats and result beats
  always @(posedge clk) begin
    ramp_result_t exp_res;
    if (!rst_n) begin
      keys_stored     = 0;
      mult_mode       = cri_pkg::CAO_SET;
      fail_count      = 0;
      req_beats       = 0;
      written_beats   = 0;
      colour_q.delete();
      colours_pending = 0;
    end else begin
      if (psel && penable && pwrite && paddr == 3'(cri_pkg::REG_COLOUR_MULTIPLY))
        mult_mode = pwdata[0];
      if (in_ch.valid && in_ch.ready) begin
        colour_q.push_back(next_colour());
        req_beats++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (colour_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          exp_res = colour_q.pop_front();
          if (exp_res.written) written_beats++;
          if (out_ch.out_red !== exp_res.r) begin
            $error("out_red expected %0d got %0d", exp_res.r, out_ch.out_red); fail_count++;
          end
          if (out_ch.out_green !== exp_res.g) begin
            $error("out_green expected %0d got %0d", exp_res.g, out_ch.out_green); fail_count++;
          end
          if (out_ch.out_blue !== exp_res.b) begin
            $error("out_blue expected %0d got %0d", exp_res.b, out_ch.out_blue); fail_count++;
          end
          if (out_ch.out_alpha !== exp_res.a) begin
            $error("out_alpha expected %0d got %0d", exp_res.a, out_ch.out_alpha); fail_count++;
          end
          if (out_ch.colour_written !== exp_res.written) begin
            $error("colour_written expected %0d got %0d", exp_res.written,
                   out_ch.colour_written);
            fail_count++;
          end
          if (out_ch.status !== exp_res.full) begin
            $error("status expected %0d got %0d", exp_res.full, out_ch.status); fail_count++;
          end
          if (out_ch.key_count !== exp_res.count) begin
            $error("key_count expected %0d got %0d", exp_res.count, out_ch.key_count);
            fail_count++;
          end
        end
      end
      colours_pending = colour_q.size();
    end
  end

endmodule

// ----- dv/tb_colour_ramp_interpolator.sv -----
// testbench top of the colour ramp interpolator: clock, reset, request and register stimulus
// depends on cri_pkg, cri_if, cri_ramp_checker and the design
`timescale 1ns / 1ps

module tb_colour_ramp_interpolator;

  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, colours_pending, req_beats, written_beats;
  int          send_idle_pct, take_idle_pct;
  int          idle_cycles;

  cri_in_if  in_ch ();
  cri_out_if out_ch ();

  colour_ramp_interpolator u_top (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  cri_ramp_checker u_checker (
    .clk, .rst_n, .in_ch, .out_ch, .psel, .penable, .pwrite, .paddr, .pwdata,
    .fail_count, .colours_pending, .req_beats, .written_beats
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= take_idle_pct);
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("colour_ramp_interpolator test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_req(input logic [1:0] req, input logic [16:0] kt,
                          input logic [31:0] rgba, input logic vis,
                          input logic [31:0] tot, input logic [31:0] rem);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.req_type = req;
    in_ch.key_time = kt;
    {in_ch.red, in_ch.green, in_ch.blue, in_ch.alpha} = rgba;
    in_ch.is_visual = vis;
    in_ch.total_life = tot;
    in_ch.remaining_life = rem;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // wait for the block to drain, then write the multiply mode
  task automatic set_mode(input logic mode);
    in_ch.valid = 1'b0;
    while (colours_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = 3'(cri_pkg::REG_COLOUR_MULTIPLY); pwdata = {31'($urandom), mode};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic send_random();
    int          pick;
    logic [16:0] kt;
    logic [31:0] tot, rem;
    pick = $urandom_range(99);
    case ($urandom_range(9))
      0:       kt = 17'(cri_pkg::TIME_ONE);
      1:       kt = 17'($urandom_range(8) * 8192);
      2:       kt = 17'($urandom_range(131071, 65537));
      default: kt = 17'($urandom_range(65536));
    endcase
    case ($urandom_range(15))
      0:       tot = 32'd0;
      1, 2:    tot = $urandom_range(20, 1);
      default: tot = $urandom;
    endcase
    if ($urandom_range(9) == 0 && tot != 32'hFFFF_FFFF) rem = $urandom_range(32'hFFFF_FFFF, tot + 1);
    else rem = $urandom_range(tot, 0);
    if (pick < 32)
      send_req(cri_pkg::REQ_INSERT, kt, $urandom, 1'($urandom), tot, rem);
    else if (pick < 36)
      send_req(cri_pkg::REQ_CLEAR, kt, $urandom, 1'($urandom), tot, rem);
    else if (pick < 39)
      send_req(cri_pkg::REQ_UNUSED, kt, $urandom, 1'($urandom), tot, rem);
    else
      send_req(cri_pkg::REQ_AFFECT, kt, $urandom, ($urandom_range(15) != 0), tot, rem);
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.req_type = cri_pkg::REQ_CLEAR; in_ch.key_time = '0;
    in_ch.red = '0; in_ch.green = '0; in_ch.blue = '0; in_ch.alpha = '0;
    in_ch.is_visual = 1'b0; in_ch.total_life = '0; in_ch.remaining_life = '0;
    out_ch.ready = 1'b0;
    idle_cycles = 0;
    send_idle_pct = 0; take_idle_pct = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, saturation, life edge cases, full table, unused request
    send_req(cri_pkg::REQ_AFFECT, 17'd0, 32'hFFFF_FFFF, cri_pkg::KIND_VISUAL, 32'd100, 32'd50);
    send_req(cri_pkg::REQ_INSERT, 17'h1FFFF, 32'hFF00_80FF, 1'b0, 32'd0, 32'd0);
    send_req(cri_pkg::REQ_INSERT, 17'd30000, 32'h1020_3040, 1'b0, 32'd0, 32'd0);
    send_req(cri_pkg::REQ_AFFECT, 17'd0, 32'h8080_8080, cri_pkg::KIND_VISUAL, 32'd1000, 32'd999);
    send_req(cri_pkg::REQ_AFFECT, 17'd0, 32'h8080_8080, cri_pkg::KIND_VISUAL, 32'd0, 32'd0);
    send_req(cri_pkg::REQ_AFFECT, 17'd0, 32'h8080_8080, cri_pkg::KIND_VISUAL, 32'd10, 32'd11);
    send_req(cri_pkg::REQ_AFFECT, 17'd0, 32'h8080_8080, cri_pkg::KIND_VISUAL, 32'd1000, 32'd0);
    send_req(cri_pkg::REQ_AFFECT, 17'd0, 32'h8080_8080, cri_pkg::KIND_VISUAL, 32'd3, 32'd1);
    send_req(cri_pkg::REQ_AFFECT, 17'd0, 32'h1234_5678, 1'b0, 32'd3, 32'd1);
    send_req(cri_pkg::REQ_INSERT, 17'd0, 32'h00FF_0000, 1'b0, 32'd0, 32'd0);
    send_req(cri_pkg::REQ_INSERT, 17'd30000, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0);
    for (int i = 1; i <= 6; i++)
      send_req(cri_pkg::REQ_INSERT, 17'(i * 9000 + 1), $urandom, 1'b0, 32'd0, 32'd0);
    send_req(cri_pkg::REQ_INSERT, 17'd12345, 32'hAAAA_AAAA, 1'b0, 32'd0, 32'd0);
    send_req(cri_pkg::REQ_INSERT, 17'd9001, 32'h5555_5555, 1'b0, 32'd0, 32'd0);
    send_req(cri_pkg::REQ_AFFECT, 17'd0, 32'hFFFF_FFFF, cri_pkg::KIND_VISUAL, 32'hFFFF_FFFF,
             32'h7FFF_FFFF);
    send_req(cri_pkg::REQ_UNUSED, 17'h1FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
             32'hFFFF_FFFF);
    set_mode(cri_pkg::CAO_MULTIPLY);
    send_req(cri_pkg::REQ_AFFECT, 17'd0, 32'hFF00_7F80, cri_pkg::KIND_VISUAL, 32'd77, 32'd20);
    send_req(cri_pkg::REQ_CLEAR, 17'd0, 32'd0, 1'b0, 32'd0, 32'd0);
    send_req(cri_pkg::REQ_AFFECT, 17'd0, 32'h0102_0304, cri_pkg::KIND_VISUAL, 32'd5, 32'd2);

    // random phases with different stall patterns and modes
    send_idle_pct = 37; take_idle_pct = 48;
    repeat (320) send_random();
    set_mode(cri_pkg::CAO_SET);
    send_idle_pct = 48; take_idle_pct = 37;
    repeat (320) send_random();
    set_mode(cri_pkg::CAO_MULTIPLY);
    send_idle_pct = 0; take_idle_pct = 0;
    repeat (310) send_random();
    in_ch.valid = 1'b0;

    while (colours_pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    $display("%0d requests sent (inserts, clears, affects, unused type), %0d colours written",
             req_beats, written_beats);
    $display("both multiply modes, three stall patterns, full and empty tables exercised");
    if (fail_count == 0) begin
      $display("colour_ramp_interpolator test passed");
    end else begin
      $display("colour_ramp_interpolator test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/cri_pkg.sv
design/cri_if.sv
design/cri_div.sv
design/colour_ramp_interpolator.sv
dv/cri_ramp_checker.sv
dv/tb_colour_ramp_interpolator.sv
